FILE: rtl/core/tsts_pkg.sv
package tsts_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int TAG_W       = 8;
   localparam int VAL_W       = 32;
   // signed index wide enough for -1 .. TABLE_DEPTH and for lo + hi
   localparam int POS_W       = IDX_W + 2;
   localparam int KEY_W       = VAL_W + 1;

   typedef logic [IDX_W-1:0]        idx_type;
   typedef logic [TAG_W-1:0]        tag_type;
   typedef logic [VAL_W-1:0]        val_type;
   typedef logic signed [POS_W-1:0] pos_type;
   typedef logic [KEY_W-1:0]        key_type;
   typedef logic signed [IDX_W:0]   sidx_type;

   typedef struct packed {
      tag_type tag;
      val_type value;
   } tbl_entry_type;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   localparam pos_type POS_ONE = pos_type'(1);

endpackage

FILE: rtl/core/tsts_if.sv
interface tsts_req_if;
   import tsts_pkg::*;

   logic    valid;
   logic    ready;
   logic    op;
   idx_type entry_index;
   tag_type entry_type;
   val_type entry_value;
   idx_type left_bound;
   idx_type right_bound;
   tag_type search_type;
   val_type search_addr;

   modport source (
      output valid, op, entry_index, entry_type, entry_value,
             left_bound, right_bound, search_type, search_addr,
      input  ready
   );
   modport sink (
      input  valid, op, entry_index, entry_type, entry_value,
             left_bound, right_bound, search_type, search_addr,
      output ready
   );
endinterface

interface tsts_rsp_if;
   import tsts_pkg::*;

   logic     valid;
   logic     ready;
   idx_type  left_index;
   sidx_type right_index;

   modport source (output valid, left_index, right_index, input ready);
   modport sink (input valid, left_index, right_index, output ready);
endinterface

FILE: rtl/core/tsts_table_ram.sv
module tsts_table_ram (
   input  logic                    clock,
   input  logic                    wr_en,
   input  tsts_pkg::idx_type       wr_addr,
   input  tsts_pkg::tbl_entry_type wr_data,
   input  tsts_pkg::idx_type       rd_addr,
   output tsts_pkg::tbl_entry_type rd_data
);
   import tsts_pkg::*;

   tbl_entry_type mem [TABLE_DEPTH];
   tbl_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/typed_sorted_table_search_core.sv
// Write word: stored at the accept edge; the result word is loaded in S_OUT once the output register is free.
// Query word: binary-search probes (S_PROBE, then S_SCAN, which steps back over entries of
//   another type behind a midpoint), then S_FINAL and the final backward scan (S_TAIL) from
//   the right bracket.
// One word at a time; the next word is taken once the result register is loaded.
// Reset clears control and the result valid flag; table contents stay undefined.
module typed_sorted_table_search_core (
   input logic         clock,
   input logic         reset,
   tsts_req_if.sink    req_chan,
   tsts_rsp_if.source  rsp_chan
);
   import tsts_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_PROBE = 6'b000010,
      S_SCAN  = 6'b000100,
      S_FINAL = 6'b001000,
      S_TAIL  = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   pos_type   lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in, m_ff, m_in;
   pos_type   res_left_ff, res_left_in, res_right_ff, res_right_in;
   logic      found_ff, found_in;
   key_type   key_ff, key_in;
   tag_type   typ_ff, typ_in;
   logic      rsp_valid_ff, rsp_valid_in;
   idx_type   rsp_left_ff, rsp_left_in;
   sidx_type  rsp_right_ff, rsp_right_in;

   logic          accept;
   logic          wr_en;
   idx_type       rd_addr;
   tbl_entry_type rd_data;
   tbl_entry_type wr_data;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign wr_en          = accept && (req_chan.op == OP_WRITE);
   assign wr_data        = '{tag: req_chan.entry_type, value: req_chan.entry_value};

   tsts_table_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_chan.entry_index),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      pos_type sum;
      pos_type mid;
      pos_type m_dec;
      key_type entry_key;

      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      m_in         = m_ff;
      res_left_in  = res_left_ff;
      res_right_in = res_right_ff;
      found_in     = found_ff;
      key_in       = key_ff;
      typ_in       = typ_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rd_addr      = m_ff[IDX_W-1:0];

      sum       = lo_ff + hi_ff;
      mid       = sum >>> 1;
      m_dec     = m_ff - POS_ONE;
      entry_key = {1'b0, rd_data.value};

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_chan.op == OP_WRITE) begin
                  res_left_in  = '0;
                  res_right_in = '0;
                  state_in     = S_OUT;
               end else begin
                  lo_in        = pos_type'({2'b00, req_chan.left_bound});
                  hi_in        = pos_type'({2'b00, req_chan.right_bound});
                  res_left_in  = pos_type'({2'b00, req_chan.left_bound});
                  res_right_in = pos_type'({2'b00, req_chan.right_bound});
                  found_in     = 1'b0;
                  key_in       = {1'b0, req_chan.search_addr};
                  typ_in       = req_chan.search_type;
                  state_in     = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            if (lo_ff > hi_ff) begin
               state_in = S_FINAL;
            end else begin
               mid_in   = mid;
               m_in     = mid;
               rd_addr  = mid[IDX_W-1:0];
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // rd_data holds the entry at m_ff
            if (rd_data.tag == typ_ff) begin
               found_in = 1'b1;
               state_in = S_PROBE;
               if (entry_key < key_ff) begin
                  res_left_in = m_ff;
                  lo_in       = mid_ff + POS_ONE;
               end else if (entry_key > key_ff) begin
                  res_right_in = m_dec;
                  hi_in        = m_dec;
               end else begin
                  // exact hit: keep going right past equal addresses
                  res_left_in = m_ff;
                  lo_in       = m_ff;
                  key_in      = key_ff + key_type'(1);
               end
            end else if (m_dec < lo_ff) begin
               lo_in    = mid_ff + POS_ONE;
               state_in = S_PROBE;
            end else begin
               m_in    = m_dec;
               rd_addr = m_dec[IDX_W-1:0];
            end
         end
         S_FINAL: begin
            if (!found_ff) begin
               res_right_in = res_left_ff - POS_ONE;
               state_in     = S_OUT;
            end else if (res_right_ff > res_left_ff) begin
               m_in     = res_right_ff;
               rd_addr  = res_right_ff[IDX_W-1:0];
               state_in = S_TAIL;
            end else begin
               res_left_in = res_right_ff;
               state_in    = S_OUT;
            end
         end
         S_TAIL: begin
            // walk back from the right bracket to the last entry of the type
            if (rd_data.tag == typ_ff) begin
               res_left_in = m_ff;
               state_in    = S_OUT;
            end else if (m_dec > res_left_ff) begin
               m_in    = m_dec;
               rd_addr = m_dec[IDX_W-1:0];
            end else begin
               res_left_in = m_dec;
               state_in    = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = res_left_ff[IDX_W-1:0];
               rsp_right_in = res_right_ff[IDX_W:0];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      m_ff         <= m_in;
      res_left_ff  <= res_left_in;
      res_right_ff <= res_right_in;
      key_ff       <= key_in;
      typ_ff       <= typ_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.left_index  = rsp_left_ff;
   assign rsp_chan.right_index = rsp_right_ff;

endmodule

FILE: verif/tsts_search_check.sv
module tsts_search_check
   import tsts_pkg::*;
(
   input  logic clock,
   input  logic reset,
   tsts_req_if  req_mon,
   tsts_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_count,
   output int   write_count,
   output int   query_count
);

   typedef struct packed {
      idx_type  left;
      sidx_type right;
   } bracket_type;

   tag_type     stored_tag [TABLE_DEPTH];
   val_type     stored_val [TABLE_DEPTH];
   bracket_type expected_brackets [$];
   int          mismatches = 0;
   int          result_count = 0;
   int          writes_seen = 0;
   int          queries_seen = 0;

   task automatic report_mismatch(input string msg);
      if (mismatches < 30) begin
         $display("MISMATCH @%0t: %s", $time, msg);
      end
      mismatches++;
   endtask

   // typed binary search; key is one bit wider so an exact hit at the top
   // address steps past every stored value
   function automatic bracket_type predict_bracket(input int lb, input int rb,
                                                   input tag_type st, input val_type addr);
      logic [KEY_W-1:0] key;
      int               lo, hi, mid, m, k, res_l, res_r;
      bit               found;
      bracket_type      b;
      key   = {1'b0, addr};
      lo    = lb;
      hi    = (rb > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : rb;
      res_l = lb;
      res_r = hi;
      found = 1'b0;
      while (lo <= hi) begin
         mid = (lo + hi) / 2;
         m   = mid;
         while (m >= lo && stored_tag[m] != st) m--;
         if (m < lo) begin
            lo = mid + 1;
         end else begin
            found = 1'b1;
            if ({1'b0, stored_val[m]} < key) begin
               res_l = m;
               lo    = mid + 1;
            end else if ({1'b0, stored_val[m]} > key) begin
               res_r = m - 1;
               hi    = m - 1;
            end else begin
               res_l = m;
               lo    = m;
               key   = key + 1'b1;
            end
         end
      end
      if (!found) begin
         res_r = res_l - 1;
      end else begin
         k = res_r;
         while (k > res_l && stored_tag[k] != st) k--;
         res_l = k;
      end
      b.left  = idx_type'(res_l);
      b.right = sidx_type'(res_r);
      return b;
   endfunction

   always @(posedge clock) begin
      bracket_type want;
      if (reset) begin
         expected_brackets.delete();
      end else begin
         // results first: a word accepted this edge cannot have answered yet
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_brackets.size() == 0) begin
               report_mismatch($sformatf("result word %0d with nothing pending", result_count));
            end else begin
               want = expected_brackets.pop_front();
               if (rsp_mon.left_index !== want.left) begin
                  report_mismatch($sformatf("word %0d left_index got %0d want %0d",
                                            result_count, rsp_mon.left_index, want.left));
               end
               if (rsp_mon.right_index !== want.right) begin
                  report_mismatch($sformatf("word %0d right_index got %0d want %0d",
                                            result_count, rsp_mon.right_index, want.right));
               end
            end
            result_count++;
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.op == OP_WRITE) begin
               stored_tag[req_mon.entry_index] = req_mon.entry_type;
               stored_val[req_mon.entry_index] = req_mon.entry_value;
               want = '0;
               writes_seen++;
            end else begin
               want = predict_bracket(int'(req_mon.left_bound), int'(req_mon.right_bound),
                                      req_mon.search_type, req_mon.search_addr);
               queries_seen++;
            end
            expected_brackets.push_back(want);
         end
      end
      pending_count <= expected_brackets.size();
      fail_count    <= mismatches;
      write_count   <= writes_seen;
      query_count   <= queries_seen;
   end

endmodule

FILE: verif/tb_typed_sorted_table_search_core.sv
module tb_typed_sorted_table_search_core;
   import tsts_pkg::*;

   localparam int CYCLE_LIMIT = 20_000_000;
   localparam int ITEM_TARGET = 1350;
   localparam int HOLD_CYCLES = 400;
   localparam tag_type COMMON_TAGS [6] = '{8'h00, 8'h03, 8'h5A, 8'h81, 8'hC4, 8'hFF};

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   int   words_sent = 0;
   int   burst_left = 0;
   bit   hold_request = 1'b0;
   int   fail_count, pending_count, write_count, query_count;

   // stimulus-side copy of the table, used only to pick interesting queries
   tag_type shadow_tag [TABLE_DEPTH];
   val_type shadow_val [TABLE_DEPTH];
   bit      written [TABLE_DEPTH];

   tsts_req_if req_chan();
   tsts_rsp_if rsp_chan();

   typed_sorted_table_search_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   tsts_search_check u_search_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .write_count   (write_count),
      .query_count   (query_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d words still pending", cycle_count,
                  pending_count);
         $display("Verification failed");
         $finish;
      end
   end

   function automatic tag_type pick_tag();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return COMMON_TAGS[r % 6];
      return tag_type'($urandom);
   endfunction

   task automatic send_word(input op_type op, input idx_type eidx, input tag_type etag,
                            input val_type eval, input idx_type lb, input idx_type rb,
                            input tag_type st, input val_type sa);
      int gap, r;
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else begin
         r   = $urandom_range(0, 99);
         gap = (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(4, 40);
         if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(20, 80);
      end
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.op          <= op;
      req_chan.entry_index <= eidx;
      req_chan.entry_type  <= etag;
      req_chan.entry_value <= eval;
      req_chan.left_bound  <= lb;
      req_chan.right_bound <= rb;
      req_chan.search_type <= st;
      req_chan.search_addr <= sa;
      do @(posedge clock); while (!req_chan.ready);
      words_sent++;
   endtask

   task automatic write_entry(input int idx, input tag_type tag, input val_type value);
      shadow_tag[idx] = tag;
      shadow_val[idx] = value;
      written[idx]    = 1'b1;
      send_word(OP_WRITE, idx_type'(idx), tag, value, idx_type'($urandom),
                idx_type'($urandom), tag_type'($urandom), $urandom);
   endtask

   task automatic search(input int lb, input int rb, input tag_type st, input val_type sa);
      send_word(OP_QUERY, idx_type'($urandom), tag_type'($urandom), $urandom,
                idx_type'(lb), idx_type'(rb), st, sa);
   endtask

   // receiver: random stalls, free-running stretches, and a long hold on request
   initial begin
      int stall_left, free_left, r;
      stall_left = 0;
      free_left  = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (free_left > 0) begin
            free_left--;
            rsp_chan.ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp_chan.ready <= 1'b1;
            end else if (r < 65) begin
               free_left = $urandom_range(30, 150);
               rsp_chan.ready <= 1'b1;
            end else begin
               stall_left = (r < 93) ? $urandom_range(0, 3) : $urandom_range(10, 60);
               rsp_chan.ready <= 1'b0;
            end
         end
      end
   end

   initial begin
      int              seg_base, seg_len, seg_last, next_base, n_types, lb, rb, k, r;
      int              holds_started;
      bit              sorted;
      tag_type         seg_tags [3];
      longint unsigned run_val [3];
      longint unsigned step;
      tag_type         st;
      val_type         sa;

      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.op          <= OP_WRITE;
      req_chan.entry_index <= '0;
      req_chan.entry_type  <= '0;
      req_chan.entry_value <= '0;
      req_chan.left_bound  <= '0;
      req_chan.right_bound <= '0;
      req_chan.search_type <= '0;
      req_chan.search_addr <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // small hand-built table: two interleaved types, a duplicate, the top address
      write_entry(0, 8'h05, 32'd100);
      write_entry(1, 8'h09, 32'd7);
      write_entry(2, 8'h05, 32'd200);
      write_entry(3, 8'h05, 32'd200);
      write_entry(4, 8'h09, 32'd50);
      write_entry(5, 8'h05, 32'hFFFF_FFFF);
      write_entry(6, 8'h00, 32'd0);
      write_entry(7, 8'hFF, 32'hFFFF_FFFF);
      write_entry(1022, 8'h00, 32'd0);
      write_entry(1023, 8'hFF, 32'hFFFF_FFFF);
      search(0, 7, 8'h05, 32'd150);
      search(0, 7, 8'h05, 32'd200);          // duplicate exact hits
      search(0, 7, 8'h05, 32'hFFFF_FFFF);    // exact hit at top address
      search(0, 7, 8'h05, 32'd50);           // below all, bound at zero
      search(2, 7, 8'h05, 32'd10);           // below all, bound inside table
      search(0, 7, 8'h4D, 32'd5);            // no entry of the type
      search(5, 3, 8'h05, 32'd5);            // empty range
      search(0, 0, 8'h05, 32'd100);
      search(1022, 1023, 8'hFF, 32'hFFFF_FFFF);
      search(1022, 1023, 8'h00, 32'd0);
      search(0, 7, 8'h09, 32'd7);
      search(0, 7, 8'hFF, 32'd0);

      next_base     = 8;
      holds_started = 0;
      while (words_sent < ITEM_TARGET) begin
         // segment of entries, addresses ascending per type (mostly)
         seg_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 12);
         seg_base = ($urandom_range(0, 9) < 7) ? next_base : $urandom_range(0, TABLE_DEPTH - 1);
         if (seg_base + seg_len > TABLE_DEPTH) seg_len = TABLE_DEPTH - seg_base;
         seg_last  = seg_base + seg_len - 1;
         next_base = (seg_last + 1) % TABLE_DEPTH;
         n_types   = $urandom_range(1, 3);
         sorted    = ($urandom_range(0, 9) != 0);
         for (int t = 0; t < 3; t++) begin
            seg_tags[t] = pick_tag();
            run_val[t]  = ($urandom_range(0, 9) == 0) ? 0 : ($urandom >> $urandom_range(0, 31));
         end
         for (int i = seg_base; i <= seg_last; i++) begin
            k = $urandom_range(0, n_types - 1);
            if (!sorted) begin
               sa = $urandom;
            end else begin
               sa   = val_type'(run_val[k]);
               step = ($urandom_range(0, 3) == 0) ? 0 :
                      longint'($urandom_range(1, 1000)) << $urandom_range(0, 22);
               run_val[k] = run_val[k] + step;
               if (run_val[k] > 64'hFFFF_FFFF) run_val[k] = 64'hFFFF_FFFF;
            end
            write_entry(i, seg_tags[k], sa);
         end

         if (holds_started < 2 && words_sent >= 400 + 500 * holds_started) begin
            hold_request = 1'b1;
            holds_started++;
         end

         repeat ($urandom_range(2, 8)) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
               lb = $urandom_range(1, TABLE_DEPTH - 1);
               rb = $urandom_range(0, lb - 1);
            end else if (r < 20) begin
               // wide range over a fully written stretch
               lb = $urandom_range(0, TABLE_DEPTH - 1);
               if (!written[lb]) lb = seg_base;
               rb = lb;
               while (rb < TABLE_DEPTH - 1 && written[rb + 1]) rb++;
               if ($urandom_range(0, 1) == 1) begin
                  while (lb > 0 && written[lb - 1]) lb--;
               end
               rb = $urandom_range(lb, rb);
            end else begin
               lb = $urandom_range(seg_base, seg_last);
               rb = $urandom_range(lb, seg_last);
            end
            if (lb <= rb && $urandom_range(0, 3) != 0) begin
               st = shadow_tag[$urandom_range(lb, rb)];
            end else begin
               st = pick_tag();
            end
            sa = (lb <= rb) ? shadow_val[$urandom_range(lb, rb)] : $urandom;
            case ($urandom_range(0, 9))
               0, 1, 2, 3: ;
               4, 5: sa = sa + 1'b1;
               6: sa = sa - 1'b1;
               7: sa = '0;
               8: sa = '1;
               default: sa = $urandom;
            endcase
            search(lb, rb, st, sa);
         end
      end

      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (20) @(posedge clock);

      $display("Covered %0d table writes and %0d typed searches in %0d cycles,",
               write_count, query_count, cycle_count);
      $display("including two long result-side holds and %0d mismatches.", fail_count);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
